// ===== hw/rtl/swstat_pkg.sv =====
// types and constants for the sample window statistics block
// no dependencies; used by sample_window_statistics by scoped names

package swstat_pkg;

    // window storage depth, a power of two
    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CAP_W        = 7;
    localparam int SMP_W        = 32;
    localparam int TOT_W        = SMP_W + ADDR_W;
    localparam int FRAC_W       = 8;
    localparam int DIV_W        = TOT_W + FRAC_W;
    localparam int MEAN_W       = 40;
    localparam int DCNT_W       = $clog2(DIV_W + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [SMP_W-1:0] S32_MIN   = 32'h8000_0000;
    localparam logic [SMP_W-1:0] S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0] U32_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_POP,
        ST_SETTLE,
        ST_LOAD,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] sample_temperature;
        logic [31:0]        sample_pressure;
        logic [31:0]        sample_time;
    } t_item;

    typedef struct packed {
        logic               status;
        logic [6:0]         sample_count;
        logic signed [31:0] popped_temperature;
        logic [31:0]        popped_pressure;
        logic [31:0]        popped_time;
        logic [31:0]        window_start_time;
        logic signed [31:0] temperature_max;
        logic signed [31:0] temperature_min;
        logic signed [39:0] temperature_mean;
        logic [31:0]        pressure_max;
        logic [31:0]        pressure_min;
        logic [39:0]        pressure_mean;
    } t_result;

    // one window entry as stored in the sample memory
    typedef struct packed {
        logic [SMP_W-1:0] temperature;
        logic [SMP_W-1:0] pressure;
        logic [SMP_W-1:0] timestamp;
    } t_entry;

endpackage

// ===== hw/rtl/sample_window_statistics.sv =====
// sliding window of sensor samples with high, low and mean reporting
// depends on swstat_pkg (types, opcodes, widths)

// usage
// - command channel: an item (opcode plus sample) is taken when start is high
//   and busy is low; busy stays high until the item's result is produced
// - opcodes: push a sample, pop the oldest sample, clear the window, or query
// - result channel: o_result is valid for exactly one cycle while o_done is
//   high; the receiver has no way to stall it, so it must take it then
// - config channel: i_cfg_data is the window capacity, written when
//   i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high and the
//   capacity is only to be changed while the block is idle
// - samples live in one 64 entry memory with a registered read; the scan for
//   high and low reads one entry per cycle, and the two means come from a
//   pair of bit-serial dividers (one quotient bit per cycle, 46 bits) that run
//   alongside the scan
// - after accept, a push first evicts the oldest samples one by one until the
//   window has room and then stores its sample, a pop removes the oldest sample
//   if any, and every item then loads the dividers and runs the scan
// - one item at a time; a new item can be accepted in the cycle o_done is high
// - reset: window empty, running totals zero, capacity 64; memory contents
//   are left as they are and never read before being written

module sample_window_statistics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  swstat_pkg::t_item                   i_item,
    output logic                                o_done,
    output swstat_pkg::t_result                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swstat_pkg::CAP_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = swstat_pkg::ADDR_W;
    localparam int CNT_W  = swstat_pkg::CNT_W;
    localparam int TOT_W  = swstat_pkg::TOT_W;
    localparam int DIV_W  = swstat_pkg::DIV_W;
    localparam int SMP_W  = swstat_pkg::SMP_W;
    localparam int MEAN_W = swstat_pkg::MEAN_W;
    localparam int FRAC_W = swstat_pkg::FRAC_W;
    localparam int DCNT_W = swstat_pkg::DCNT_W;

    // sample memory
    swstat_pkg::t_entry r_mem [swstat_pkg::WINDOW_DEPTH];
    swstat_pkg::t_entry r_rdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_we;
    swstat_pkg::t_entry mem_wdata;

    // control state
    swstat_pkg::t_state r_state, n_state;
    logic [swstat_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]   eff_cap;
    swstat_pkg::t_item  r_item;
    logic [ADDR_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOT_W-1:0]   r_ttot, n_ttot;
    logic [TOT_W-1:0]   r_ptot, n_ptot;
    logic               r_sub_vld;
    logic               r_sub_cap;
    logic               r_status;
    swstat_pkg::t_entry r_pop;

    // scan state
    logic [CNT_W-1:0]   r_scan_k;
    logic               r_scan_vld;
    logic               r_scan_first;
    logic [SMP_W-1:0]   r_start_time;
    logic [SMP_W-1:0]   r_thigh, r_tlow, r_phigh, r_plow;

    // divider state
    logic [DIV_W-1:0]   r_tdiv, r_pdiv;
    logic [CNT_W-1:0]   r_trem, r_prem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_tneg;

    logic               r_done;
    swstat_pkg::t_result r_result;

    // controls from the fsm
    logic c_accept, c_evict, c_pop, c_push, c_clear, c_load, c_scan, c_finish;
    logic full;
    logic scan_end;

    logic [TOT_W-1:0]   sub_t, sub_p, add_t, add_p;
    logic [TOT_W-1:0]   tmag;
    logic [CNT_W-1:0]   t_shift, p_shift;
    logic               t_ge, p_ge;
    logic [MEAN_W-1:0]  q_t;

    assign busy        = (r_state != swstat_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(r_cap) > 32'(swstat_pkg::WINDOW_DEPTH)) begin
            eff_cap = CNT_W'(swstat_pkg::WINDOW_DEPTH);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    assign full     = (r_count >= eff_cap);
    assign scan_end = (r_scan_k == r_count) && !r_scan_vld && (r_dcnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swstat_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_item.opcode)
                        swstat_pkg::OP_PUSH: n_state = swstat_pkg::ST_EVICT;
                        swstat_pkg::OP_POP:  n_state = swstat_pkg::ST_POP;
                        default:             n_state = swstat_pkg::ST_SETTLE;
                    endcase
                end
            end
            swstat_pkg::ST_EVICT: begin
                if (!full) begin
                    n_state = swstat_pkg::ST_SETTLE;
                end
            end
            swstat_pkg::ST_POP:    n_state = swstat_pkg::ST_SETTLE;
            swstat_pkg::ST_SETTLE: n_state = swstat_pkg::ST_LOAD;
            swstat_pkg::ST_LOAD:   n_state = swstat_pkg::ST_SCAN;
            swstat_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = swstat_pkg::ST_IDLE;
                end
            end
            default: n_state = swstat_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        c_accept = 1'b0;
        c_evict  = 1'b0;
        c_pop    = 1'b0;
        c_push   = 1'b0;
        c_clear  = 1'b0;
        c_load   = 1'b0;
        c_scan   = 1'b0;
        c_finish = 1'b0;
        case (r_state)
            swstat_pkg::ST_IDLE: begin
                c_accept = start;
                c_clear  = start && (i_item.opcode == swstat_pkg::OP_CLEAR);
            end
            swstat_pkg::ST_EVICT: begin
                c_evict = full;
                c_push  = !full;
            end
            swstat_pkg::ST_POP: begin
                c_pop = (r_count != '0);
            end
            swstat_pkg::ST_LOAD: begin
                c_load = 1'b1;
            end
            swstat_pkg::ST_SCAN: begin
                c_scan   = (r_scan_k != r_count);
                c_finish = scan_end;
            end
            default: begin
                c_accept = 1'b0;
            end
        endcase
    end

    // memory addressing; depth is a power of two so the index wraps itself
    assign mem_raddr = c_scan ? (r_oldest + r_scan_k[ADDR_W-1:0]) : r_oldest;
    assign mem_waddr = r_oldest + r_count[ADDR_W-1:0];
    assign mem_we    = c_push;
    assign mem_wdata = '{temperature: r_item.sample_temperature,
                         pressure:    r_item.sample_pressure,
                         timestamp:   r_item.sample_time};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // running totals: the entry read for an eviction or pop arrives in the following cycle
    always_comb begin
        sub_t = r_sub_vld ? {{(TOT_W-SMP_W){r_rdata.temperature[SMP_W-1]}},
                             r_rdata.temperature} : '0;
        sub_p = r_sub_vld ? {{(TOT_W-SMP_W){1'b0}}, r_rdata.pressure} : '0;
        add_t = c_push ? {{(TOT_W-SMP_W){r_item.sample_temperature[SMP_W-1]}},
                          r_item.sample_temperature} : '0;
        add_p = c_push ? {{(TOT_W-SMP_W){1'b0}}, r_item.sample_pressure} : '0;
        if (c_clear) begin
            n_ttot = '0;
            n_ptot = '0;
        end else begin
            n_ttot = r_ttot - sub_t + add_t;
            n_ptot = r_ptot - sub_p + add_p;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_oldest = r_oldest;
        if (c_clear) begin
            n_count  = '0;
            n_oldest = '0;
        end else if (c_evict || c_pop) begin
            n_count  = r_count - CNT_W'(1);
            n_oldest = r_oldest + ADDR_W'(1);
        end else if (c_push) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // restoring division, one quotient bit per cycle
    assign tmag    = r_ttot[TOT_W-1] ? (TOT_W'(0) - r_ttot) : r_ttot;
    assign t_shift = {r_trem[CNT_W-2:0], r_tdiv[DIV_W-1]};
    assign p_shift = {r_prem[CNT_W-2:0], r_pdiv[DIV_W-1]};
    assign t_ge    = (t_shift >= r_count);
    assign p_ge    = (p_shift >= r_count);
    assign q_t     = r_tdiv[MEAN_W-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= swstat_pkg::ST_IDLE;
            r_cap      <= swstat_pkg::CAP_RESET;
            r_oldest   <= '0;
            r_count    <= '0;
            r_ttot     <= '0;
            r_ptot     <= '0;
            r_sub_vld  <= 1'b0;
            r_sub_cap  <= 1'b0;
            r_scan_vld <= 1'b0;
            r_dcnt     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_oldest   <= n_oldest;
            r_count    <= n_count;
            r_ttot     <= n_ttot;
            r_ptot     <= n_ptot;
            r_sub_vld  <= c_evict || c_pop;
            r_sub_cap  <= c_pop;
            r_scan_vld <= c_scan;
            r_done     <= c_finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (c_load) begin
                r_dcnt <= DCNT_W'(DIV_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_item   <= i_item;
            r_pop    <= '0;
            r_status <= (r_count == '0) && ((i_item.opcode == swstat_pkg::OP_POP) ||
                                            (i_item.opcode == swstat_pkg::OP_QUERY));
        end
        if (r_sub_vld && r_sub_cap) begin
            r_pop <= r_rdata;
        end

        if (c_load) begin
            r_scan_k     <= '0;
            r_scan_first <= 1'b1;
            r_start_time <= '0;
            r_thigh      <= swstat_pkg::S32_MIN;
            r_tlow       <= swstat_pkg::S32_MAX;
            r_phigh      <= '0;
            r_plow       <= swstat_pkg::U32_MAX;
            r_tneg       <= r_ttot[TOT_W-1];
            r_tdiv       <= {tmag, {FRAC_W{1'b0}}};
            r_pdiv       <= {r_ptot, {FRAC_W{1'b0}}};
            r_trem       <= '0;
            r_prem       <= '0;
        end else begin
            if (c_scan) begin
                r_scan_k <= r_scan_k + CNT_W'(1);
            end
            // compare the entry read last cycle
            if (r_scan_vld) begin
                if (r_scan_first) begin
                    r_start_time <= r_rdata.timestamp;
                    r_scan_first <= 1'b0;
                end
                if ($signed(r_rdata.temperature) > $signed(r_thigh)) begin
                    r_thigh <= r_rdata.temperature;
                end
                if ($signed(r_rdata.temperature) < $signed(r_tlow)) begin
                    r_tlow <= r_rdata.temperature;
                end
                if (r_rdata.pressure > r_phigh) begin
                    r_phigh <= r_rdata.pressure;
                end
                if (r_rdata.pressure < r_plow) begin
                    r_plow <= r_rdata.pressure;
                end
            end
            if (r_dcnt != '0) begin
                r_trem <= t_ge ? (t_shift - r_count) : t_shift;
                r_prem <= p_ge ? (p_shift - r_count) : p_shift;
                r_tdiv <= {r_tdiv[DIV_W-2:0], t_ge};
                r_pdiv <= {r_pdiv[DIV_W-2:0], p_ge};
            end
        end

        if (c_finish) begin
            r_result.status             <= r_status;
            r_result.sample_count       <= 7'(r_count);
            r_result.popped_temperature <= r_pop.temperature;
            r_result.popped_pressure    <= r_pop.pressure;
            r_result.popped_time        <= r_pop.timestamp;
            r_result.window_start_time  <= r_start_time;
            r_result.temperature_max    <= r_thigh;
            r_result.temperature_min    <= r_tlow;
            r_result.pressure_max       <= r_phigh;
            r_result.pressure_min       <= r_plow;
            if (r_count == '0) begin
                r_result.temperature_mean <= '0;
                r_result.pressure_mean    <= '0;
            end else begin
                r_result.temperature_mean <= r_tneg ? (MEAN_W'(0) - q_t) : q_t;
                r_result.pressure_mean    <= r_pdiv[MEAN_W-1:0];
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for sample_window_statistics: push, pop, clear and query items
// checked against a window predictor; needs swstat_pkg and the sample_window_statistics rtl

module testbench;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 138;
    // no accept, result or capacity write for this many cycles ends the run
    localparam int QUIET_LIMIT     = 2000;
    // idle time run after the last result, before the check for results never produced
    localparam int TAIL_CYCLES     = 150;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    swstat_pkg::t_item             cmd_item    = '0;
    logic                          o_done;
    swstat_pkg::t_result           o_result;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [swstat_pkg::CAP_W-1:0]  i_cfg_data  = '0;

    sample_window_statistics uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // items waiting to be driven, and window reports still owed by the block
    swstat_pkg::t_item   sample_cmds [$];
    swstat_pkg::t_result stats_due [$];

    int fail_count   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // handshake bookkeeping shared by driver, monitor and the sequencer
    bit item_taken = 1'b0;
    bit all_idle   = 1'b0;
    bit gaps_on    = 1'b1;
    bit drain_wait = 1'b0;
    int gap_left   = 0;

    // predictor copy of the window
    logic signed [31:0]           win_temp  [swstat_pkg::WINDOW_DEPTH];
    logic [31:0]                  win_press [swstat_pkg::WINDOW_DEPTH];
    logic [31:0]                  win_stamp [swstat_pkg::WINDOW_DEPTH];
    int                           win_head      = 0;
    int                           win_count     = 0;
    longint                       win_temp_sum  = 0;
    longint unsigned              win_press_sum = 0;
    logic [swstat_pkg::CAP_W-1:0] win_capacity  = swstat_pkg::CAP_RESET;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch at result %0d, %s: got %0h, expected %0h",
                 results_seen, what, got, want);
    endtask

    // remove the oldest sample from the running totals and return its slot
    function automatic int drop_oldest_entry();
        int pos;
        pos           = win_head;
        win_temp_sum  -= longint'(win_temp[pos]);
        win_press_sum -= 64'(win_press[pos]);
        win_head      = (pos + 1) % swstat_pkg::WINDOW_DEPTH;
        win_count--;
        return pos;
    endfunction

    // apply one item to the predictor window and build the report it causes
    function automatic swstat_pkg::t_result predict_window(input swstat_pkg::t_item it);
        swstat_pkg::t_result res;
        int                  cap;
        int                  pos;
        logic signed [31:0]  t;
        logic [31:0]         p;
        longint              tq;
        logic [63:0]         pq;
        res                 = '0;
        res.temperature_max = swstat_pkg::S32_MIN;
        res.temperature_min = swstat_pkg::S32_MAX;
        res.pressure_max    = '0;
        res.pressure_min    = swstat_pkg::U32_MAX;
        case (it.opcode)
            swstat_pkg::OP_PUSH: begin
                // zero acts as one, anything above the store depth saturates
                cap = (win_capacity == 0) ? 1 : int'(win_capacity);
                if (cap > swstat_pkg::WINDOW_DEPTH) cap = swstat_pkg::WINDOW_DEPTH;
                while (win_count >= cap) void'(drop_oldest_entry());
                pos            = (win_head + win_count) % swstat_pkg::WINDOW_DEPTH;
                win_temp[pos]  = it.sample_temperature;
                win_press[pos] = it.sample_pressure;
                win_stamp[pos] = it.sample_time;
                win_temp_sum  += longint'(it.sample_temperature);
                win_press_sum += 64'(it.sample_pressure);
                win_count++;
            end
            swstat_pkg::OP_POP: begin
                if (win_count == 0) begin
                    res.status = 1'b1;
                end else begin
                    pos                    = drop_oldest_entry();
                    res.popped_temperature = win_temp[pos];
                    res.popped_pressure    = win_press[pos];
                    res.popped_time        = win_stamp[pos];
                end
            end
            swstat_pkg::OP_CLEAR: begin
                win_count     = 0;
                win_head      = 0;
                win_temp_sum  = 0;
                win_press_sum = 0;
            end
            default: begin
                // query only
                res.status = (win_count == 0);
            end
        endcase
        res.sample_count = 7'(win_count);
        if (win_count > 0) begin
            res.window_start_time = win_stamp[win_head];
            for (int k = 0; k < win_count; k++) begin
                pos = (win_head + k) % swstat_pkg::WINDOW_DEPTH;
                t   = win_temp[pos];
                p   = win_press[pos];
                if (t > res.temperature_max) res.temperature_max = t;
                if (t < res.temperature_min) res.temperature_min = t;
                if (p > res.pressure_max)    res.pressure_max    = p;
                if (p < res.pressure_min)    res.pressure_min    = p;
            end
            // signed division truncates toward zero
            tq                   = (win_temp_sum * 64'sd256) / longint'(win_count);
            res.temperature_mean = tq[39:0];
            pq                   = (win_press_sum << 8) / 64'(win_count);
            res.pressure_mean    = pq[39:0];
        end
        return res;
    endfunction

    function automatic swstat_pkg::t_item make_item(input swstat_pkg::t_opcode op,
                                                    input logic [31:0] temp,
                                                    input logic [31:0] press,
                                                    input logic [31:0] stamp);
        swstat_pkg::t_item it;
        it.opcode             = op;
        it.sample_temperature = temp;
        it.sample_pressure    = press;
        it.sample_time        = stamp;
        return it;
    endfunction

    // append one item to the pending list
    task automatic add_cmd(input swstat_pkg::t_opcode op, input logic [31:0] temp,
                           input logic [31:0] press, input logic [31:0] stamp);
        sample_cmds = {sample_cmds, make_item(op, temp, press, stamp)};
    endtask

    // sample values lean on the corners so extremes and ties show up often
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return swstat_pkg::S32_MIN;
            3:       return swstat_pkg::S32_MAX;
            4:       return 32'($urandom_range(15));
            5:       return 32'(0 - $urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_for_idle();
        do @(negedge i_clk); while (!all_idle);
    endtask

    // driver: start and the item change only at the falling edge
    always @(negedge i_clk) begin
        logic              drive_start;
        swstat_pkg::t_item drive_item;
        drive_start = start;
        drive_item  = cmd_item;
        if (!start || item_taken) begin
            drive_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (drain_wait) begin
                // hold off until the block has answered everything
                if (stats_due.size() == 0) drain_wait = 1'b0;
            end else if (sample_cmds.size() > 0) begin
                drive_item  = sample_cmds[0];
                sample_cmds.delete(0);
                drive_start = 1'b1;
                if (gaps_on && $urandom_range(99) < 30) begin
                    gap_left = $urandom_range(15, 1);
                end else if (gaps_on && $urandom_range(99) < 2) begin
                    drain_wait = 1'b1;
                end
            end
        end
        start    <= drive_start;
        cmd_item <= drive_item;
    end

    // monitor: results are checked first, then a new accept is predicted, since
    // the block may take the next item in the same cycle it reports the last one
    always @(posedge i_clk) begin
        swstat_pkg::t_result got;
        swstat_pkg::t_result want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                got = o_result;
                results_seen++;
                if (stats_due.size() == 0) begin
                    report_mismatch("result with no item outstanding", '0, '0);
                end else begin
                    want = stats_due[0];
                    stats_due.delete(0);
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.sample_count !== want.sample_count)
                        report_mismatch("sample_count", 64'(got.sample_count),
                                        64'(want.sample_count));
                    if (got.popped_temperature !== want.popped_temperature)
                        report_mismatch("popped_temperature", 64'(got.popped_temperature),
                                        64'(want.popped_temperature));
                    if (got.popped_pressure !== want.popped_pressure)
                        report_mismatch("popped_pressure", 64'(got.popped_pressure),
                                        64'(want.popped_pressure));
                    if (got.popped_time !== want.popped_time)
                        report_mismatch("popped_time", 64'(got.popped_time),
                                        64'(want.popped_time));
                    if (got.window_start_time !== want.window_start_time)
                        report_mismatch("window_start_time", 64'(got.window_start_time),
                                        64'(want.window_start_time));
                    if (got.temperature_max !== want.temperature_max)
                        report_mismatch("temperature_max", 64'(got.temperature_max),
                                        64'(want.temperature_max));
                    if (got.temperature_min !== want.temperature_min)
                        report_mismatch("temperature_min", 64'(got.temperature_min),
                                        64'(want.temperature_min));
                    if (got.temperature_mean !== want.temperature_mean)
                        report_mismatch("temperature_mean", 64'(got.temperature_mean),
                                        64'(want.temperature_mean));
                    if (got.pressure_max !== want.pressure_max)
                        report_mismatch("pressure_max", 64'(got.pressure_max),
                                        64'(want.pressure_max));
                    if (got.pressure_min !== want.pressure_min)
                        report_mismatch("pressure_min", 64'(got.pressure_min),
                                        64'(want.pressure_min));
                    if (got.pressure_mean !== want.pressure_mean)
                        report_mismatch("pressure_mean", 64'(got.pressure_mean),
                                        64'(want.pressure_mean));
                end
            end
            if (start && busy === 1'b0) stats_due = {stats_due, predict_window(cmd_item)};
        end
        item_taken <= i_rst_n && start && busy === 1'b0;
        all_idle   <= i_rst_n && !start && busy === 1'b0 && sample_cmds.size() == 0 &&
                      stats_due.size() == 0;
    end

    // watchdog on progress of any kind
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // sequencer: reset, a directed opening, then random phases, each under its
    // own capacity written while the block is idle
    initial begin
        logic [swstat_pkg::CAP_W-1:0] cap;
        swstat_pkg::t_opcode          op;
        bit                           deep;
        int                           r;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty window: pop and query flag it, clear is harmless
        add_cmd(swstat_pkg::OP_POP,   '0, '0, '0);
        add_cmd(swstat_pkg::OP_QUERY, '0, '0, '0);
        add_cmd(swstat_pkg::OP_CLEAR, '0, '0, '0);
        // field extremes
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MIN, '0, '0);
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MAX, swstat_pkg::U32_MAX,
                swstat_pkg::U32_MAX);
        add_cmd(swstat_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'd1, 32'd5);
        add_cmd(swstat_pkg::OP_QUERY, '0, '0, '0);
        // drain to empty, the last pop leaves the sentinel values behind
        add_cmd(swstat_pkg::OP_POP, '0, '0, '0);
        add_cmd(swstat_pkg::OP_POP, '0, '0, '0);
        add_cmd(swstat_pkg::OP_POP, '0, '0, '0);
        add_cmd(swstat_pkg::OP_POP, '0, '0, '0);
        // negative mean with a fraction, truncated toward zero
        add_cmd(swstat_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'd3, 32'd10);
        add_cmd(swstat_pkg::OP_PUSH, '0, '0, 32'd11);
        add_cmd(swstat_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'd2, 32'd12);
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MIN, 32'h8000_0000, 32'd13);
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MIN, swstat_pkg::U32_MAX, 32'd14);
        add_cmd(swstat_pkg::OP_CLEAR, '0, '0, '0);
        add_cmd(swstat_pkg::OP_QUERY, '0, '0, '0);
        // large positive sums
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MAX, swstat_pkg::U32_MAX, 32'd1);
        add_cmd(swstat_pkg::OP_PUSH, swstat_pkg::S32_MAX, swstat_pkg::U32_MAX, 32'd2);
        add_cmd(swstat_pkg::OP_QUERY, '0, '0, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_idle();
            case (ph)
                0:       cap = 7'd1;    // a push into a non-empty window evicts
                1:       cap = 7'd0;    // behaves as one
                2:       cap = 7'd127;  // saturates to the store depth
                3:       cap = 7'd2;    // lowered below a full window
                4:       cap = 7'd65;
                5:       cap = 7'd64;
                6:       cap = 7'd3;    // lowered again, first push evicts many
                7:       cap = 7'd8;
                9:       cap = 7'd64;
                default: cap = 7'($urandom_range(64, 1));
            endcase
            i_cfg_data  <= cap;
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            win_capacity = cap;
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            // deep phases mostly push and never clear, so the window fills up
            deep    = (ph == 2 || ph == 4 || ph == 5 || ph == 9);
            gaps_on = (ph != NUM_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (deep) begin
                    if (r < 80)      op = swstat_pkg::OP_PUSH;
                    else if (r < 90) op = swstat_pkg::OP_POP;
                    else             op = swstat_pkg::OP_QUERY;
                end else begin
                    if (r < 50)      op = swstat_pkg::OP_PUSH;
                    else if (r < 80) op = swstat_pkg::OP_POP;
                    else if (r < 95) op = swstat_pkg::OP_QUERY;
                    else             op = swstat_pkg::OP_CLEAR;
                end
                add_cmd(op, pick_word(), pick_word(), pick_word());
            end
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (stats_due.size() != 0)
            report_mismatch("results never produced", '0, 64'(stats_due.size()));
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
